>>> src/idea_pkg.sv
// Shared types, constants and arithmetic for the IDEA cipher core.
package idea_pkg;

	localparam int SUBKEY_COUNT = 52;
	localparam int ROUND_COUNT = 8;
	localparam int INV_COUNT = SUBKEY_COUNT / 3 + 1;
	localparam int ROTATE_BITS = 25;
	localparam int IDX_W = 2;
	localparam int CNT_W = $clog2(INV_COUNT);
	localparam int INV_STEPS = 30;
	localparam int STEP_W = $clog2(INV_STEPS);

	localparam logic [IDX_W-1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [IDX_W-1:0] REG_KEY_LOW = 2'd1;
	localparam logic [IDX_W-1:0] REG_MODE = 2'd2;

	typedef logic [15:0] word_t;
	typedef word_t subkeys_t [SUBKEY_COUNT];
	typedef word_t round_keys_t [6];

	// Multiply modulo 65537, the word zero standing for 65536
	function automatic word_t idea_mul(input word_t a, input word_t b);
		logic [31:0] p;
		word_t lo;
		word_t hi;
		word_t r;
		p = {16'd0, a} * {16'd0, b};
		lo = p[15:0];
		hi = p[31:16];
		if (a == 16'd0) begin
			r = 16'd1 - b;
		end else if (b == 16'd0) begin
			r = 16'd1 - a;
		end else begin
			r = lo - hi + {15'd0, (lo < hi)};
		end
		return r;
	endfunction

endpackage

>>> src/idea_round.sv
// One IDEA round cut into three pipeline stages.
module idea_round (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_v,
	input  logic [63:0]                 in_words,
	input  idea_pkg::round_keys_t       rk,
	output logic                        out_v,
	output logic [63:0]                 out_words
);

	logic v_s1, v_s2, v_s3;
	idea_pkg::word_t a_s1, b_s1, c_s1, d_s1;
	idea_pkg::word_t a_s2, b_s2, c_s2, d_s2, t1_s2;
	idea_pkg::word_t a_s3, b_s3, c_s3, d_s3, t1_s3, t2_s3;
	idea_pkg::word_t t3;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Key mixing, then the two multiplications of the MA structure
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= idea_pkg::idea_mul(in_words[63:48], rk[0]);
			b_s1 <= in_words[47:32] + rk[1];
			c_s1 <= in_words[31:16] + rk[2];
			d_s1 <= idea_pkg::idea_mul(in_words[15:0], rk[3]);
			t1_s2 <= idea_pkg::idea_mul(a_s1 ^ c_s1, rk[4]);
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			c_s2 <= c_s1;
			d_s2 <= d_s1;
			t2_s3 <= idea_pkg::idea_mul(t1_s2 + (b_s2 ^ d_s2), rk[5]);
			t1_s3 <= t1_s2;
			a_s3 <= a_s2;
			b_s3 <= b_s2;
			c_s3 <= c_s2;
			d_s3 <= d_s2;
		end
	end

	// Fold the MA output back into the words
	assign t3 = t1_s3 + t2_s3;
	assign out_words = {a_s3 ^ t2_s3, c_s3 ^ t2_s3, b_s3 ^ t3, d_s3 ^ t3};
	assign out_v = v_s3;

endmodule

>>> src/idea_keysched.sv
// Key registers, subkey expansion and sequential decryption-key inversion.
module idea_keysched (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [idea_pkg::IDX_W-1:0]   wr_index,
	input  logic [63:0]                  wr_data,
	output logic                         busy,
	output idea_pkg::subkeys_t           subkeys
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOAD  = 4'b0010,
		ST_START = 4'b0100,
		ST_RUN   = 4'b1000
	} ks_state_t;

	ks_state_t state_q;
	logic [63:0] key_high_q, key_low_q;
	logic mode_q;
	logic [127:0] key;
	idea_pkg::subkeys_t enc, dec, sk_q;
	idea_pkg::word_t inv_q [idea_pkg::INV_COUNT];
	idea_pkg::word_t acc_q, mul_op, mul_res;
	logic [idea_pkg::STEP_W-1:0] step_q;
	logic [idea_pkg::CNT_W-1:0] cnt_q;
	logic hit;

	assign key = {key_high_q, key_low_q};

	// Slice encryption subkeys out of the rotated key
	for (genvar j = 0; j < idea_pkg::SUBKEY_COUNT; j++) begin : g_enc
		localparam int S = (idea_pkg::ROTATE_BITS * (j / 8) + 16 * (j % 8)) % 128;
		logic [255:0] rot;
		assign rot = {key, key} << S;
		assign enc[j] = rot[255:240];
	end

	// Arrange decryption subkeys; inverted slots still hold raw values
	always_comb begin
		dec[0] = enc[48];
		dec[1] = 16'd0 - enc[49];
		dec[2] = 16'd0 - enc[50];
		dec[3] = enc[51];
		dec[4] = enc[46];
		dec[5] = enc[47];
		for (int r = 1; r < idea_pkg::ROUND_COUNT; r++) begin
			dec[6*r]   = enc[48-6*r];
			dec[6*r+1] = 16'd0 - enc[50-6*r];
			dec[6*r+2] = 16'd0 - enc[49-6*r];
			dec[6*r+3] = enc[51-6*r];
			dec[6*r+4] = enc[46-6*r];
			dec[6*r+5] = enc[47-6*r];
		end
		dec[48] = enc[0];
		dec[49] = 16'd0 - enc[1];
		dec[50] = 16'd0 - enc[2];
		dec[51] = enc[3];
	end

	// Decode register writes
	always_comb begin
		unique case (wr_index)
			idea_pkg::REG_KEY_HIGH, idea_pkg::REG_KEY_LOW, idea_pkg::REG_MODE: hit = wr_en;
			default: hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			mode_q <= 1'b0;
		end else if (wr_en) begin
			if (wr_index == idea_pkg::REG_KEY_HIGH) key_high_q <= wr_data;
			if (wr_index == idea_pkg::REG_KEY_LOW) key_low_q <= wr_data;
			if (wr_index == idea_pkg::REG_MODE) mode_q <= wr_data[0];
		end
	end

	// Inversion as x^65535: alternate squaring and multiplying by x
	assign mul_op = step_q[0] ? inv_q[0] : acc_q;
	assign mul_res = idea_pkg::idea_mul(acc_q, mul_op);

	// Sequence loading and inversion; any write to a defined register restarts it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			step_q <= '0;
			cnt_q <= '0;
		end else if (hit) begin
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_IDLE: state_q <= ST_IDLE;
				ST_LOAD: begin
					cnt_q <= '0;
					state_q <= mode_q ? ST_START : ST_IDLE;
				end
				ST_START: begin
					step_q <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (step_q == idea_pkg::STEP_W'(idea_pkg::INV_STEPS - 1)) begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= (cnt_q == idea_pkg::CNT_W'(idea_pkg::INV_COUNT - 1))
							? ST_IDLE : ST_START;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold subkeys; rotate the inversion ring one slot per finished inverse
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			for (int j = 0; j < idea_pkg::SUBKEY_COUNT; j++)
				sk_q[j] <= mode_q ? dec[j] : enc[j];
			for (int c = 0; c < idea_pkg::INV_COUNT; c++)
				inv_q[c] <= mode_q ? dec[3*c] : enc[3*c];
		end else if (state_q == ST_START) begin
			acc_q <= inv_q[0];
		end else if (state_q == ST_RUN) begin
			if (step_q == idea_pkg::STEP_W'(idea_pkg::INV_STEPS - 1)) begin
				for (int c = 0; c < idea_pkg::INV_COUNT - 1; c++)
					inv_q[c] <= inv_q[c+1];
				inv_q[idea_pkg::INV_COUNT-1] <= mul_res;
			end else begin
				acc_q <= mul_res;
			end
		end
	end

	// Every third slot comes from the inversion ring
	always_comb begin
		for (int j = 0; j < idea_pkg::SUBKEY_COUNT; j++)
			subkeys[j] = (j % 3 == 0) ? inv_q[j/3] : sk_q[j];
	end

	assign busy = (state_q != ST_IDLE);

endmodule

>>> src/idea_block_cipher_core.sv
// Top level of the IDEA cipher core: key schedule, eight round pipelines, output stage.
// IDEA encrypt/decrypt engine, 64-bit words under a 128-bit key. One word enters per
// cycle while in_stall is low; each of the eight rounds takes three stages (one
// modular multiplication deep per stage) and the output half-round one more. The whole
// pipeline moves together and holds while a finished word waits under out_stall. Any
// write to one of the three registers restarts the key schedule and holds in_stall high
// meanwhile: in encrypt mode for the load step only, in decrypt mode also while the 18
// multiplicative inverses go one after another through a single multiplier. The same
// load runs after reset with an all-zero key.
module idea_block_cipher_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [63:0]                 block_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [63:0]                 block_out,
	input  logic                        wr_en,
	input  logic [idea_pkg::IDX_W-1:0]  wr_index,
	input  logic [63:0]                 wr_data
);

	idea_pkg::subkeys_t subkeys;
	logic busy, en;
	logic v [idea_pkg::ROUND_COUNT+1];
	logic [63:0] w [idea_pkg::ROUND_COUNT+1];
	logic [63:0] blk_s1;
	logic v_s1;

	idea_keysched u_keysched (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .busy(busy), .subkeys(subkeys)
	);

	// Advance whenever the output slot can move
	assign en = !(out_valid && out_stall);
	assign in_stall = !en || busy;

	assign v[0] = in_valid && !in_stall;
	assign w[0] = block_in;

	for (genvar r = 0; r < idea_pkg::ROUND_COUNT; r++) begin : g_round
		idea_pkg::round_keys_t rk;
		for (genvar i = 0; i < 6; i++) begin : g_rk
			assign rk[i] = subkeys[6*r+i];
		end
		idea_round u_round (
			.clk(clk), .arst_n(arst_n), .en(en), .in_v(v[r]), .in_words(w[r]),
			.rk(rk), .out_v(v[r+1]), .out_words(w[r+1])
		);
	end

	// Output half-round into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= v[idea_pkg::ROUND_COUNT];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blk_s1 <= {
				idea_pkg::idea_mul(w[idea_pkg::ROUND_COUNT][63:48], subkeys[48]),
				w[idea_pkg::ROUND_COUNT][31:16] + subkeys[49],
				w[idea_pkg::ROUND_COUNT][47:32] + subkeys[50],
				idea_pkg::idea_mul(w[idea_pkg::ROUND_COUNT][15:0], subkeys[51])
			};
		end
	end

	assign out_valid = v_s1;
	assign block_out = blk_s1;

endmodule

>>> src/idea_checker.sv
// Port-level checks for the IDEA cipher core, bound to the top level.
module idea_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [63:0]                 block_out,
	input logic                        wr_en,
	input logic [idea_pkg::IDX_W-1:0]  wr_index
);

	// A stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(block_out))
		else $error("stalled output word changed");

	// Back-pressure reaches the input
	a_back_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output stalled");

	// A register write holds the input off while subkeys are rebuilt
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && (wr_index == idea_pkg::REG_KEY_HIGH || wr_index == idea_pkg::REG_KEY_LOW
			|| wr_index == idea_pkg::REG_MODE) |=> in_stall)
		else $error("input taken during key expansion");

endmodule

bind idea_block_cipher_core idea_checker u_idea_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .block_out(block_out), .wr_en(wr_en), .wr_index(wr_index)
);

>>> bench/idea_block_cipher_core_tb.sv
// Self-checking bench for the IDEA cipher core: directed table, random blocks, key changes.
`timescale 1ns / 100ps

module idea_block_cipher_core_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_WORDS = 500;
	localparam int MAX_REPORTS = 10;
	// index with no register behind it
	localparam logic [idea_pkg::IDX_W-1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic [63:0] blk;
		logic        has_expect;
		logic [63:0] want;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [63:0] block_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [63:0] block_out;
	logic wr_en = 1'b0;
	logic [idea_pkg::IDX_W-1:0] wr_index = idea_pkg::REG_KEY_HIGH;
	logic [63:0] wr_data = '0;

	// shadow of the key registers and the subkeys in force
	logic [63:0] key_hi_q = '0;
	logic [63:0] key_lo_q = '0;
	logic        decrypt_q = 1'b0;
	logic [15:0] subkeys [idea_pkg::SUBKEY_COUNT];

	logic [63:0] expected_blocks [$];
	int errors = 0;
	int reported = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;
	bit random_go = 1'b0;

	idea_block_cipher_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .block_in(block_in),
		.out_valid(out_valid), .out_stall(out_stall), .block_out(block_out),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] mod_mul(logic [15:0] a, logic [15:0] b);
		logic [31:0] p;
		logic [15:0] lo;
		logic [15:0] hi;
		if (a == 16'd0) return 16'd1 - b;
		if (b == 16'd0) return 16'd1 - a;
		p = {16'd0, a} * {16'd0, b};
		lo = p[15:0];
		hi = p[31:16];
		return lo - hi + {15'd0, (lo < hi)};
	endfunction

	// raise to 65535 modulo 65537; zero means 65536
	function automatic logic [15:0] mod_inv(logic [15:0] x);
		logic [63:0] base;
		logic [63:0] acc;
		logic [31:0] e;
		base = (x == 16'd0) ? 64'd65536 : {48'd0, x};
		acc = 64'd1;
		e = 32'd65535;
		while (e != 0) begin
			if (e[0]) acc = (acc * base) % 64'd65537;
			base = (base * base) % 64'd65537;
			e = e >> 1;
		end
		return acc[15:0];
	endfunction

	function automatic logic [15:0] add_neg(logic [15:0] x);
		return 16'd0 - x;
	endfunction

	// rebuild the subkey set from the shadow key and mode
	task automatic rebuild_subkeys();
		logic [127:0] key;
		logic [15:0] enc [idea_pkg::SUBKEY_COUNT];
		int start;
		int d;
		int e;
		key = {key_hi_q, key_lo_q};
		for (int j = 0; j < idea_pkg::SUBKEY_COUNT; j++) begin
			start = (idea_pkg::ROTATE_BITS * (j / 8) + 16 * (j % 8)) % 128;
			for (int k = 0; k < 16; k++)
				enc[j][15-k] = key[127 - ((start + k) % 128)];
		end
		if (!decrypt_q) begin
			for (int j = 0; j < idea_pkg::SUBKEY_COUNT; j++) subkeys[j] = enc[j];
		end else begin
			subkeys[0] = mod_inv(enc[48]);
			subkeys[1] = add_neg(enc[49]);
			subkeys[2] = add_neg(enc[50]);
			subkeys[3] = mod_inv(enc[51]);
			subkeys[4] = enc[46];
			subkeys[5] = enc[47];
			for (int r = 1; r < idea_pkg::ROUND_COUNT; r++) begin
				d = 6 * r;
				e = 48 - 6 * r;
				subkeys[d] = mod_inv(enc[e]);
				subkeys[d+1] = add_neg(enc[e+2]);
				subkeys[d+2] = add_neg(enc[e+1]);
				subkeys[d+3] = mod_inv(enc[e+3]);
				subkeys[d+4] = enc[e-2];
				subkeys[d+5] = enc[e-1];
			end
			subkeys[48] = mod_inv(enc[0]);
			subkeys[49] = add_neg(enc[1]);
			subkeys[50] = add_neg(enc[2]);
			subkeys[51] = mod_inv(enc[3]);
		end
	endtask

	function automatic logic [63:0] cipher_block(logic [63:0] blk);
		logic [15:0] w0, w1, w2, w3, a, b, c, d, t1, t2, t3;
		int s;
		w0 = blk[63:48]; w1 = blk[47:32]; w2 = blk[31:16]; w3 = blk[15:0];
		for (int r = 0; r < idea_pkg::ROUND_COUNT; r++) begin
			s = 6 * r;
			a = mod_mul(w0, subkeys[s]);
			b = w1 + subkeys[s+1];
			c = w2 + subkeys[s+2];
			d = mod_mul(w3, subkeys[s+3]);
			t1 = mod_mul(a ^ c, subkeys[s+4]);
			t2 = mod_mul(t1 + (b ^ d), subkeys[s+5]);
			t3 = t1 + t2;
			w0 = a ^ t2; w1 = c ^ t2; w2 = b ^ t3; w3 = d ^ t3;
		end
		return {mod_mul(w0, subkeys[48]), w2 + subkeys[49], w1 + subkeys[50],
			mod_mul(w3, subkeys[51])};
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
			(($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
	endfunction

	// offer one word and hold it until accepted; drop valid only across a gap
	task automatic send_word(logic [63:0] blk, bit has_want, logic [63:0] want);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		block_in <= blk;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_blocks.push_back(has_want ? want : cipher_block(blk));
		@(negedge clk);
	endtask

	// wait for the pipeline to empty, then write one register
	task automatic write_reg(logic [idea_pkg::IDX_W-1:0] idx, logic [63:0] val);
		in_valid <= 1'b0;
		while (expected_blocks.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			idea_pkg::REG_KEY_HIGH: key_hi_q = val;
			idea_pkg::REG_KEY_LOW:  key_lo_q = val;
			idea_pkg::REG_MODE:     decrypt_q = val[0];
			default: ;
		endcase
		rebuild_subkeys();
	endtask

	task automatic random_phase(int count);
		logic [63:0] blk;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 5))
				0: blk = '0;
				1: blk = '1;
				default: blk = {$urandom, $urandom};
			endcase
			send_word(blk, 1'b0, '0);
		end
	endtask

	// receiver: random stalls, outside a forced hold-off
	always @(negedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else if ($urandom_range(0, 24) == 0) out_stall <= 1'b1;
		else if ($urandom_range(0, 2) == 0) out_stall <= ($urandom_range(0, 3) == 0);
		else out_stall <= 1'b0;
	end

	// compare each accepted word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_blocks.size() == 0) begin
				errors++;
				if (reported < MAX_REPORTS) begin
					reported++;
					$display("unexpected word %h", block_out);
				end
			end else begin
				if (block_out !== expected_blocks[0]) begin
					errors++;
					if (reported < MAX_REPORTS) begin
						reported++;
						$display("block_out mismatch: expected %h got %h",
							expected_blocks[0], block_out);
					end
				end
				void'(expected_blocks.pop_front());
			end
		end
	end

	// watchdog on cycles without any accepted word or register write
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// long receiver hold-off while the sender keeps offering random words
	initial begin
		wait (random_go);
		repeat (50) @(negedge clk);
		hold_off = 1'b1;
		repeat (120) @(negedge clk);
		hold_off = 1'b0;
	end

	vector_t vectors [] = '{
		'{64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
		'{64'h0001_0002_0003_0004, 1'b0, 64'h0},
		'{64'h8000_0000_0000_0001, 1'b0, 64'h0},
		'{64'h0000_FFFF_0000_FFFF, 1'b0, 64'h0},
		'{64'hFFFF_0000_FFFF_0000, 1'b0, 64'h0}
	};
	vector_t known [] = '{
		// published test vector for key 0001 0002 ... 0008
		'{64'h0000_0001_0002_0003, 1'b1, 64'h11FB_ED2B_0198_6DE5},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
		'{64'h0000_0000_0000_0000, 1'b0, 64'h0}
	};

	initial begin
		rebuild_subkeys();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// all-zero key after reset, then the extreme rows
		foreach (vectors[i]) send_word(vectors[i].blk, vectors[i].has_expect, vectors[i].want);
		write_reg(idea_pkg::REG_KEY_HIGH, 64'h0001_0002_0003_0004);
		write_reg(idea_pkg::REG_KEY_LOW, 64'h0005_0006_0007_0008);
		foreach (known[i]) send_word(known[i].blk, known[i].has_expect, known[i].want);
		// decrypt mode brings the ciphertext back
		write_reg(idea_pkg::REG_MODE, 64'd1);
		send_word(64'h11FB_ED2B_0198_6DE5, 1'b1, 64'h0000_0001_0002_0003);
		// only bit 0 of the mode counts; out-of-range index is ignored
		write_reg(idea_pkg::REG_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
		write_reg(REG_NONE, 64'h1234);
		send_word(64'h0123_4567_89AB_CDEF, 1'b0, '0);
		write_reg(idea_pkg::REG_KEY_HIGH, '1);
		write_reg(idea_pkg::REG_KEY_LOW, '1);
		send_word('1, 1'b0, '0);
		write_reg(idea_pkg::REG_MODE, 64'd1);
		send_word('0, 1'b0, '0);

		// random keys and modes, mostly encrypt to keep the schedule short
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(idea_pkg::REG_KEY_HIGH, {$urandom, $urandom});
			write_reg(idea_pkg::REG_KEY_LOW, {$urandom, $urandom});
			write_reg(idea_pkg::REG_MODE, {63'd0, ph[0]});
			random_go = 1'b1;
			random_phase(RANDOM_WORDS / 5);
		end

		in_valid <= 1'b0;
		while (expected_blocks.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/idea_pkg.sv
src/idea_round.sv
src/idea_keysched.sv
src/idea_block_cipher_core.sv
src/idea_checker.sv
bench/idea_block_cipher_core_tb.sv
